FILE: src/joint_trajectory_interpolator_unit_assert.svh
// Assertion macros used by the interpolator's pipeline control.
`ifndef JOINT_TRAJECTORY_INTERPOLATOR_UNIT_ASSERT_SVH
`define JOINT_TRAJECTORY_INTERPOLATOR_UNIT_ASSERT_SVH

// The consequent must hold at every clock edge outside reset at which the antecedent holds.
`define JTI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold at the clock edge that follows the antecedent.
`define JTI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/jti_pkg.sv
package jti_pkg;

  localparam int ANGLE_W = 32;
  localparam int PHASE_W = 17;
  localparam int PHASE_FRAC_W = 16;
  localparam int MODE_W = 3;
  localparam int NUM_STAGES = 7;

  localparam logic [MODE_W-1:0] MODE_SINE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LINEAR = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CUBIC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUINTIC = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STEP = 3'd4;
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_CUBIC;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
  localparam logic [17:0] CUBIC_K = 18'd196608;
  localparam logic [19:0] QUINT_A = 20'd983040;
  localparam logic [19:0] QUINT_B = 20'd655360;
  localparam logic [19:0] QUINT_C = 20'd6;
  localparam logic [15:0] ROUND_Q16 = 16'd32768;
  localparam logic [29:0] ROUND_Q30 = 30'h2000_0000;

  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int SINE_W = 33;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_OVER_PI_Q32 = 64'd2734261102;

  typedef logic signed [SINE_W-1:0] sine_word_t;
  typedef sine_word_t sine_tab_t [SINE_TABLE_DEPTH];

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } jti_ctl_t;

  function automatic longint unsigned udiv_shift(longint unsigned num, longint unsigned den);
    longint unsigned q, rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // Quarter-wave reduction and an eight-term Taylor series, evaluated at elaboration.
  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    longint unsigned n, quad, r, x, x2, term, mag, dv;
    longint sum;
    int k, i;
    for (k = 0; k < SINE_TABLE_DEPTH; k++) begin
      n = 4 * k;
      quad = n / SINE_TABLE_DEPTH;
      r = n % SINE_TABLE_DEPTH;
      if (quad == 1 || quad == 3) begin
        r = SINE_TABLE_DEPTH - r;
      end
      if (quad >= 4) begin
        r = 0;
      end
      x = (PI_HALF_Q30 * r + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = $signed(x);
      for (i = 1; i <= 7; i++) begin
        term = (term * x2 + (64'd1 << 29)) >> 30;
        dv = (2 * i) * (2 * i + 1);
        term = udiv_shift(term, dv);
        if (i % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > (64'sd1 <<< 30)) begin
        sum = 64'sd1 <<< 30;
      end
      mag = ($unsigned(sum) * TWO_OVER_PI_Q32 + (64'd1 << 29)) >> 30;
      if (quad == 2 || quad == 3) begin
        tab[k] = sine_word_t'(64'd0 - mag);
      end else begin
        tab[k] = sine_word_t'(mag);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

FILE: src/jti_pipe_ctrl.sv
`include "joint_trajectory_interpolator_unit_assert.svh"

module jti_pipe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output jti_pkg::jti_ctl_t ctl
);
  import jti_pkg::*;

  logic [NUM_STAGES-1:0] v_r;
  logic [NUM_STAGES-1:0] v_nxt;
  logic [NUM_STAGES-1:0] en;
  logic [NUM_STAGES-1:0] upstream;
  logic                  in_xfer;
  logic                  out_xfer;

  // A stage may take new data when it is empty or its contents move on.
  always_comb begin
    en[NUM_STAGES-1] = !v_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign upstream = {v_r[NUM_STAGES-2:0], in_valid};
  assign v_nxt = (en & upstream) | (~en & v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = en[0];
  assign out_valid = v_r[NUM_STAGES-1];
  assign ctl.load = en & upstream;

  assign in_xfer = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  `JTI_ASSERT_NXT(a_in_lands, clk, rst_n, in_xfer, v_r[0], "accepted transfer missing in first stage")
  `JTI_ASSERT_IMP(a_empty_ready, clk, rst_n, !v_r[0], in_ready, "empty first stage refused a transfer")
  `JTI_ASSERT_NXT(a_count, clk, rst_n, 1'b1, $countones(v_r) == $countones($past(v_r)) + $past(in_xfer) - $past(out_xfer), "items lost or duplicated in the pipeline")

endmodule

FILE: src/joint_trajectory_interpolator_unit.sv
// Joint trajectory interpolator. Each transfer carries one joint's start angle, goal angle
// (signed Q3.28) and motion phase (unsigned Q1.16) and yields one reference angle, weighted
// between start and goal by the profile in the mode register: sine ramp, linear, cubic,
// quintic or step to goal, and the start angle for any other mode value. A phase of one
// or more returns the goal angle with reached set. The datapath is a seven-stage pipeline
// that accepts a new item every cycle while the output is not stalled; the multiplier
// stages and the sine table look-up set that depth. The block holds no state between
// items, and the mode register must only be written while no item is in flight.
module joint_trajectory_interpolator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [jti_pkg::ANGLE_W-1:0]  in_start_angle,
  input  logic signed [jti_pkg::ANGLE_W-1:0]  in_goal_angle,
  input  logic        [jti_pkg::PHASE_W-1:0]  in_phase,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [jti_pkg::ANGLE_W-1:0]  out_reference_angle,
  output logic                                out_reached,
  input  logic                                cfg_we,
  input  logic        [jti_pkg::MODE_W-1:0]   cfg_wdata
);
  import jti_pkg::*;

  jti_ctl_t              ctl;
  logic [NUM_STAGES-1:0] ld;
  logic [MODE_W-1:0]     mode_r;

  // Stage 1
  logic [PHASE_FRAC_W-1:0] p_in;
  logic [SINE_ADDR_W-1:0]  k_a;
  logic [SINE_ADDR_W-1:0]  k_b;
  logic [19:0]             qk;
  logic [31:0]             pp1_nxt, pp1_r;
  logic [35:0]             m1_nxt, m1_r;
  logic signed [32:0]      diff1_nxt, diff1_r;
  logic [PHASE_FRAC_W-1:0] p1_r;
  logic                    over1_r;
  logic signed [ANGLE_W-1:0] start1_r, goal1_r;
  sine_word_t              sa1_r, sb1_r;

  // Stage 2
  logic [17:0]             ck;
  logic [49:0]             cub_full;
  logic [47:0]             cube_full;
  logic [19:0]             mr;
  logic signed [33:0]      dlt;
  logic [15:0]             frac;
  logic [33:0]             cubw2_nxt, cubw2_r;
  logic [31:0]             c2_nxt, c2_r;
  logic [19:0]             inner2_nxt, inner2_r;
  logic signed [50:0]      df2_nxt, df2_r;
  sine_word_t              sa2_r;
  logic [PHASE_FRAC_W-1:0] p2_r;
  logic                    over2_r;
  logic signed [ANGLE_W-1:0] start2_r, goal2_r;
  logic signed [32:0]      diff2_r;

  // Stage 3
  logic signed [35:0]      s_sum;
  logic signed [35:0]      lin;
  logic [51:0]             ci3_nxt, ci3_r;
  logic signed [35:0]      ws3_nxt, ws3_r;
  logic [33:0]             cubw3_r;
  logic [PHASE_FRAC_W-1:0] p3_r;
  logic                    over3_r;
  logic signed [ANGLE_W-1:0] start3_r, goal3_r;
  logic signed [32:0]      diff3_r;

  // Stage 4
  logic [35:0]             quint;
  logic signed [36:0]      w4_nxt, w4_r;
  logic                    over4_r;
  logic signed [ANGLE_W-1:0] start4_r, goal4_r;
  logic signed [32:0]      diff4_r;

  // Stage 5
  logic [32:0]             wc;
  logic [32:0]             dabs;
  logic [30:0]             w30_nxt, w30_r;
  logic [31:0]             mag5_nxt, mag5_r;
  logic                    neg5_r;
  logic                    over5_r;
  logic signed [ANGLE_W-1:0] start5_r, goal5_r;

  // Stage 6
  logic [62:0]             prod;
  logic [31:0]             off6_nxt, off6_r;
  logic                    neg6_r;
  logic                    over6_r;
  logic signed [ANGLE_W-1:0] start6_r, goal6_r;

  // Stage 7
  logic signed [33:0]      ref_sum;
  logic signed [ANGLE_W-1:0] ref7_nxt, ref7_r;
  logic                    over7_r;

  jti_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .ctl       (ctl)
  );

  assign ld = ctl.load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Stage 1: products of the phase, table samples and the angle difference.
  always_comb begin
    p_in = in_phase[PHASE_FRAC_W-1:0];
    k_a = p_in[PHASE_FRAC_W-1 -: SINE_ADDR_W];
    k_b = k_a + SINE_ADDR_W'(1);
    pp1_nxt = 32'(p_in) * 32'(p_in);
    qk = QUINT_A - 20'(p_in) * QUINT_C;
    m1_nxt = 36'(p_in) * 36'(qk);
    diff1_nxt = 33'(in_goal_angle) - 33'(in_start_angle);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      p1_r     <= p_in;
      over1_r  <= in_phase[PHASE_FRAC_W];
      start1_r <= in_start_angle;
      goal1_r  <= in_goal_angle;
      pp1_r    <= pp1_nxt;
      m1_r     <= m1_nxt;
      diff1_r  <= diff1_nxt;
      sa1_r    <= SINE_TABLE[k_a];
      sb1_r    <= SINE_TABLE[k_b];
    end
  end

  // Stage 2
  always_comb begin
    ck = CUBIC_K - 18'({p1_r, 1'b0});
    cub_full = 50'(pp1_r) * 50'(ck);
    cubw2_nxt = 34'((cub_full + 50'(ROUND_Q16)) >> 16);
    cube_full = 48'(pp1_r) * 48'(p1_r);
    c2_nxt = 32'((cube_full + 48'(ROUND_Q16)) >> 16);
    mr = 20'((m1_r + 36'(ROUND_Q16)) >> 16);
    inner2_nxt = QUINT_B - mr;
    dlt = 34'(sb1_r) - 34'(sa1_r);
    frac = p1_r << SINE_ADDR_W;
    df2_nxt = 51'(dlt) * 51'($signed({1'b0, frac}));
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      cubw2_r  <= cubw2_nxt;
      c2_r     <= c2_nxt;
      inner2_r <= inner2_nxt;
      df2_r    <= df2_nxt;
      sa2_r    <= sa1_r;
      p2_r     <= p1_r;
      over2_r  <= over1_r;
      start2_r <= start1_r;
      goal2_r  <= goal1_r;
      diff2_r  <= diff1_r;
    end
  end

  // Stage 3
  always_comb begin
    ci3_nxt = 52'(c2_r) * 52'(inner2_r);
    s_sum = 36'(sa2_r) + 36'(df2_r >>> 16);
    lin = $signed(36'({p2_r, 16'h0000}));
    ws3_nxt = lin - s_sum;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      ci3_r    <= ci3_nxt;
      ws3_r    <= ws3_nxt;
      cubw3_r  <= cubw2_r;
      p3_r     <= p2_r;
      over3_r  <= over2_r;
      start3_r <= start2_r;
      goal3_r  <= goal2_r;
      diff3_r  <= diff2_r;
    end
  end

  // Stage 4: profile selection.
  always_comb begin
    quint = 36'((ci3_r + 52'(ROUND_Q16)) >> 16);
    case (mode_r)
      MODE_SINE:    w4_nxt = 37'(ws3_r);
      MODE_LINEAR:  w4_nxt = $signed(37'({p3_r, 16'h0000}));
      MODE_CUBIC:   w4_nxt = $signed(37'(cubw3_r));
      MODE_QUINTIC: w4_nxt = $signed(37'(quint));
      MODE_STEP:    w4_nxt = $signed(37'(ONE_Q32));
      default:      w4_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      w4_r     <= w4_nxt;
      over4_r  <= over3_r;
      start4_r <= start3_r;
      goal4_r  <= goal3_r;
      diff4_r  <= diff3_r;
    end
  end

  // Stage 5: clamp the weight, round it to Q30 and take the magnitude of the difference.
  always_comb begin
    if (w4_r < 0) begin
      wc = '0;
    end else if (w4_r > $signed(37'(ONE_Q32))) begin
      wc = ONE_Q32;
    end else begin
      wc = 33'(w4_r);
    end
    w30_nxt = 31'((34'(wc) + 34'd2) >> 2);
    dabs = diff4_r[32] ? 33'(-diff4_r) : 33'(diff4_r);
    mag5_nxt = dabs[31:0];
  end

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      w30_r    <= w30_nxt;
      mag5_r   <= mag5_nxt;
      neg5_r   <= diff4_r[32];
      over5_r  <= over4_r;
      start5_r <= start4_r;
      goal5_r  <= goal4_r;
    end
  end

  // Stage 6
  always_comb begin
    prod = 63'(mag5_r) * 63'(w30_r);
    off6_nxt = 32'((64'(prod) + 64'(ROUND_Q30)) >> 30);
  end

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      off6_r   <= off6_nxt;
      neg6_r   <= neg5_r;
      over6_r  <= over5_r;
      start6_r <= start5_r;
      goal6_r  <= goal5_r;
    end
  end

  // Stage 7: apply the offset and saturate, or pass the goal angle once the phase reaches one.
  always_comb begin
    if (neg6_r) begin
      ref_sum = 34'(start6_r) - $signed({2'b00, off6_r});
    end else begin
      ref_sum = 34'(start6_r) + $signed({2'b00, off6_r});
    end
    if (over6_r) begin
      ref7_nxt = goal6_r;
    end else if (ref_sum > $signed(34'(32'h7FFF_FFFF))) begin
      ref7_nxt = 32'sh7FFF_FFFF;
    end else if (ref_sum < -$signed(34'(33'h0_8000_0000))) begin
      ref7_nxt = 32'sh8000_0000;
    end else begin
      ref7_nxt = 32'(ref_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      ref7_r  <= ref7_nxt;
      over7_r <= over6_r;
    end
  end

  assign out_reference_angle = ref7_r;
  assign out_reached = over7_r;

endmodule

FILE: bench/profile_checker.sv
module profile_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [jti_pkg::ANGLE_W-1:0]  in_start_angle,
  input  logic signed [jti_pkg::ANGLE_W-1:0]  in_goal_angle,
  input  logic        [jti_pkg::PHASE_W-1:0]  in_phase,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [jti_pkg::ANGLE_W-1:0]  out_reference_angle,
  input  logic                                out_reached,
  input  logic                                cfg_we,
  input  logic        [jti_pkg::MODE_W-1:0]   cfg_wdata,
  output int                                  mismatches,
  output int                                  waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import jti_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic               reached;
  } joint_ref_t;

  localparam u64_t   WAVE_DEPTH = SINE_TABLE_DEPTH;
  localparam u64_t   HALF_PI_Q30 = 64'd1686629713;
  localparam u64_t   INV_HALF_PI_Q32 = 64'd2734261102;
  localparam u64_t   UNIT_Q16 = 64'd65536;
  localparam longint UNIT_Q32 = 64'sd4294967296;
  localparam longint ANGLE_HI = 64'sd2147483647;
  localparam longint ANGLE_LO = -64'sd2147483648;

  joint_ref_t           inflight_refs[$];
  logic [MODE_W-1:0]    profile_mode_q;
  int                   fail_count = 0;

  // sin(2*pi*k/D)*2/pi in signed Q32, built by quarter-wave reduction.
  function automatic longint wave_sample(u64_t k);
    u64_t   n, quad, r, x, x2, term, mag;
    longint acc;
    n = 4 * k;
    quad = n / WAVE_DEPTH;
    r = n % WAVE_DEPTH;
    if (quad == 1 || quad == 3) begin
      r = WAVE_DEPTH - r;
    end
    if (quad >= 4) begin
      r = 0;
    end
    x = (HALF_PI_Q30 * r + WAVE_DEPTH / 2) / WAVE_DEPTH;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    acc = longint'(x);
    for (int i = 1; i <= 7; i++) begin
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = term / u64_t'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (64'sd1 <<< 30)) begin
      acc = 64'sd1 <<< 30;
    end
    mag = (u64_t'(acc) * INV_HALF_PI_Q32 + (64'd1 << 29)) >> 30;
    return (quad == 2 || quad == 3) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint sine_ramp_weight(u64_t p);
    u64_t   pos, k, f;
    longint a, b, d, s;
    pos = p * WAVE_DEPTH;
    k = pos >> 16;
    f = pos & 64'hFFFF;
    if (k >= WAVE_DEPTH) begin
      k = WAVE_DEPTH - 1;
    end
    a = wave_sample(k);
    b = wave_sample(k + 1);
    d = b - a;
    if (d >= 0) begin
      s = a + longint'((u64_t'(d) * f) >> 16);
    end else begin
      s = a - longint'((u64_t'(-d) * f + 64'hFFFF) >> 16);
    end
    return longint'(p << 16) - s;
  endfunction

  function automatic joint_ref_t interpolate(logic [MODE_W-1:0] mode,
                                             logic signed [ANGLE_W-1:0] start,
                                             logic signed [ANGLE_W-1:0] goal,
                                             logic [PHASE_W-1:0] phase);
    joint_ref_t r;
    u64_t       p, m, inner, c, w30, span, offset;
    longint     w, diff, res;
    p = u64_t'(phase);
    if (p >= UNIT_Q16) begin
      r.angle = goal;
      r.reached = 1'b1;
      return r;
    end
    case (mode)
      MODE_SINE: begin
        w = sine_ramp_weight(p);
      end
      MODE_LINEAR: begin
        w = longint'(p << 16);
      end
      MODE_CUBIC: begin
        w = longint'((p * p * (64'd196608 - 2 * p) + 64'd32768) >> 16);
      end
      MODE_QUINTIC: begin
        m = p * (64'd983040 - 6 * p);
        inner = 64'd655360 - ((m + 64'd32768) >> 16);
        c = (p * p * p + 64'd32768) >> 16;
        w = longint'((c * inner + 64'd32768) >> 16);
      end
      MODE_STEP: begin
        w = UNIT_Q32;
      end
      default: begin
        w = 0;
      end
    endcase
    if (w < 0) begin
      w = 0;
    end
    if (w > UNIT_Q32) begin
      w = UNIT_Q32;
    end
    w30 = (u64_t'(w) + 2) >> 2;
    diff = longint'(goal) - longint'(start);
    span = (diff < 0) ? u64_t'(-diff) : u64_t'(diff);
    offset = (span * w30 + (64'd1 << 29)) >> 30;
    if (diff < 0) begin
      res = longint'(start) - longint'(offset);
    end else begin
      res = longint'(start) + longint'(offset);
    end
    if (res > ANGLE_HI) begin
      res = ANGLE_HI;
    end
    if (res < ANGLE_LO) begin
      res = ANGLE_LO;
    end
    r.angle = res[ANGLE_W-1:0];
    r.reached = 1'b0;
    return r;
  endfunction

  // A result transfer is checked before the input transfer of the same edge is predicted,
  // and a mode write only takes effect for later transfers.
  always @(posedge clk) begin : track
    joint_ref_t want;
    if (!rst_n) begin
      profile_mode_q = MODE_RESET;
      inflight_refs.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (inflight_refs.size() == 0) begin
          fail_count = fail_count + 1;
          $display("%0t ns: unexpected result, expected none, got angle %0d reached %0b",
                   $time, out_reference_angle, out_reached);
        end else begin
          want = inflight_refs.pop_front();
          if (out_reference_angle !== want.angle) begin
            fail_count = fail_count + 1;
            $display("%0t ns: reference_angle expected %0d, got %0d",
                     $time, $signed(want.angle), out_reference_angle);
          end
          if (out_reached !== want.reached) begin
            fail_count = fail_count + 1;
            $display("%0t ns: reached expected %0b, got %0b",
                     $time, want.reached, out_reached);
          end
        end
      end
      if (in_valid && in_ready) begin
        inflight_refs.push_back(interpolate(profile_mode_q, in_start_angle, in_goal_angle,
                                            in_phase));
      end
      if (cfg_we) begin
        profile_mode_q = cfg_wdata;
      end
    end
    waiting <= inflight_refs.size();
    mismatches <= fail_count;
  end

endmodule

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import jti_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = 32'sh8000_0000;
  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = 32'sh7FFF_FFFF;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 150;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [ANGLE_W-1:0]  in_start_angle;
  logic signed [ANGLE_W-1:0]  in_goal_angle;
  logic        [PHASE_W-1:0]  in_phase;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [ANGLE_W-1:0]  out_reference_angle;
  logic                       out_reached;
  logic                       cfg_we;
  logic        [MODE_W-1:0]   cfg_wdata;
  int                         mismatches;
  int                         waiting;
  int                         idle_run = 0;
  bit                         quiet = 1'b0;

  joint_trajectory_interpolator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_angle      (in_start_angle),
    .in_goal_angle       (in_goal_angle),
    .in_phase            (in_phase),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_reference_angle (out_reference_angle),
    .out_reached         (out_reached),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  profile_checker ref_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_start_angle      (in_start_angle),
    .in_goal_angle       (in_goal_angle),
    .in_phase            (in_phase),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_reference_angle (out_reference_angle),
    .out_reached         (out_reached),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .mismatches          (mismatches),
    .waiting             (waiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    case ($urandom_range(0, 9))
      0: return ANGLE_MIN;
      1: return ANGLE_MAX;
      2, 3, 4: return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [PHASE_W-1:0] pick_phase();
    case ($urandom_range(0, 19))
      0: return 17'h00000;
      1: return 17'h0FFFF;
      2: return 17'h10000;
      3: return 17'h1FFFF;
      4, 5: return 17'($urandom_range(17'h10000, 17'h1FFFF));
      default: return 17'($urandom_range(0, 17'h0FFFF));
    endcase
  endfunction

  task automatic send_joint(logic signed [ANGLE_W-1:0] start, logic signed [ANGLE_W-1:0] goal,
                            logic [PHASE_W-1:0] phase);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_angle <= start;
    in_goal_angle <= goal;
    in_phase <= phase;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_profile(logic [MODE_W-1:0] mode);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed_group(logic [PHASE_W-1:0] done_phase);
    send_joint(ANGLE_MIN, ANGLE_MAX, 17'h0FFFF);
    send_joint(ANGLE_MAX, ANGLE_MIN, 17'h08000);
    send_joint(pick_angle(), pick_angle(), 17'h00000);
    send_joint(pick_angle(), pick_angle(), done_phase);
  endtask

  initial begin : sink
    int stall;
    out_ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // The run is abandoned when no transfer happens on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin : stimulus
    logic signed [ANGLE_W-1:0] s_angle;
    logic signed [ANGLE_W-1:0] g_angle;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_start_angle <= '0;
    in_goal_angle <= '0;
    in_phase <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first group runs on the mode left by reset.
    directed_group(17'h10000);
    set_profile(MODE_SINE);
    directed_group(17'h1FFFF);
    set_profile(MODE_LINEAR);
    directed_group(17'h10000);
    set_profile(MODE_QUINTIC);
    directed_group(17'h1FFFF);
    set_profile(MODE_STEP);
    directed_group(17'h10000);
    set_profile(MODE_SPARE_HI);
    directed_group(17'h1FFFF);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_profile(MODE_SINE);
        1: set_profile(MODE_QUINTIC);
        2: set_profile(MODE_SPARE_LO);
        3: set_profile(MODE_CUBIC);
        4: set_profile(MODE_LINEAR);
        5: set_profile(MODE_SPARE_MID);
        6: set_profile(MODE_STEP);
        7: set_profile(MODE_SINE);
        default: set_profile(3'($urandom_range(0, 7)));
      endcase
      quiet = (ph % 4 == 2);
      repeat (ITEMS_PER_PHASE) begin
        s_angle = pick_angle();
        if ($urandom_range(0, 3) == 0) begin
          g_angle = s_angle + 32'($urandom_range(0, 4095)) - 32'd2048;
        end else begin
          g_angle = pick_angle();
        end
        send_joint(s_angle, g_angle, pick_phase());
      end
    end

    quiet = 1'b0;
    drain();
    if (mismatches == 0 && waiting == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/jti_pkg.sv
src/jti_pipe_ctrl.sv
src/joint_trajectory_interpolator_unit.sv
bench/profile_checker.sv
bench/tb_top.sv
